// ===== sv/iffs_pkg.sv =====
package iffs_pkg;

	localparam int MAX_LINE_BYTES = 2048;
	localparam int MAX_LINE_PAIRS = 512;

	localparam int PAIR_W = 9;
	localparam int COL_W  = 11;
	localparam int BYTE_W = 8;
	localparam int MODE_W = 2;

	localparam int STORE_DEPTH = MAX_LINE_PAIRS * MAX_LINE_BYTES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_FLIP       = 2'd0;
	localparam mode_t MODE_SHIFT      = 2'd1;
	localparam mode_t MODE_SHIFT_FLIP = 2'd2;
	localparam mode_t MODE_FLIP_SHIFT = 2'd3;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		byte_t wdata;
		logic  re;
		addr_t raddr;
	} ram_req_t;

	// positions beyond the frame alias onto the store
	function automatic addr_t store_addr(input logic [PAIR_W-1:0] pair,
			input logic [COL_W-1:0] col);
		return ADDR_W'((ADDR_W'(pair) % MAX_LINE_PAIRS) * MAX_LINE_BYTES
			+ (ADDR_W'(col) % MAX_LINE_BYTES));
	endfunction

endpackage

// ===== sv/iffs_in_if.sv =====
interface iffs_in_if;
	logic                        valid;
	logic                        ready;
	logic [iffs_pkg::PAIR_W-1:0] line_pair;
	logic [iffs_pkg::COL_W-1:0]  byte_column;
	logic [iffs_pkg::BYTE_W-1:0] top_byte;
	logic [iffs_pkg::BYTE_W-1:0] bottom_byte;

	modport source (output valid, line_pair, byte_column, top_byte, bottom_byte,
		input ready);
	modport sink (input valid, line_pair, byte_column, top_byte, bottom_byte,
		output ready);
endinterface

// ===== sv/iffs_out_if.sv =====
interface iffs_out_if;
	logic                        valid;
	logic                        ready;
	logic [iffs_pkg::PAIR_W-1:0] out_line_pair;
	logic [iffs_pkg::COL_W-1:0]  out_byte_column;
	logic [iffs_pkg::BYTE_W-1:0] out_top_byte;
	logic [iffs_pkg::BYTE_W-1:0] out_bottom_byte;

	modport source (output valid, out_line_pair, out_byte_column, out_top_byte,
		out_bottom_byte, input ready);
	modport sink (input valid, out_line_pair, out_byte_column, out_top_byte,
		out_bottom_byte, output ready);
endinterface

// ===== sv/iffs_field_ram.sv =====
module iffs_field_ram (
	input  logic               clk,
	input  logic               arst_n,
	input  iffs_pkg::ram_req_t req,
	output iffs_pkg::byte_t    rdata,
	output logic               busy
);

	iffs_pkg::byte_t mem [iffs_pkg::STORE_DEPTH];
	iffs_pkg::byte_t rdata_q;
	iffs_pkg::addr_t clr_addr_q;
	logic            busy_q;

	// zero sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == iffs_pkg::ADDR_W'(iffs_pkg::STORE_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// ===== sv/interlaced_field_flip_shift.sv =====
// Pipeline: an accepted word passes the stage-1 register, then the output register.
// Throughput: one word per cycle unless results.ready or the RAM sweep stalls it;
// the field RAM reads at accept and, in the shift modes, writes the same entry back
// as the word leaves stage 1, with a bypass register covering back-to-back hits.
// Reset: mode_q returns to flip, then a zero sweep clears all 1,048,576 field RAM
// entries, one per cycle, with items.ready held low; cfg writes still land.
module interlaced_field_flip_shift (
	input  logic                        clk,
	input  logic                        arst_n,
	iffs_in_if.sink                     items,
	iffs_out_if.source                  results,
	input  logic                        cfg_wr_en,
	input  logic [iffs_pkg::MODE_W-1:0] cfg_wr_data
);

	iffs_pkg::mode_t    mode_q;
	iffs_pkg::ram_req_t ram_req;
	iffs_pkg::byte_t    ram_rdata;
	logic               ram_busy;

	logic                        valid_s1;
	logic [iffs_pkg::PAIR_W-1:0] pair_s1;
	logic [iffs_pkg::COL_W-1:0]  col_s1;
	iffs_pkg::byte_t             top_s1;
	iffs_pkg::byte_t             bot_s1;
	iffs_pkg::addr_t             addr_s1;

	logic            byp_valid_q;
	iffs_pkg::addr_t byp_addr_q;
	iffs_pkg::byte_t byp_data_q;

	logic                        out_valid_q;
	logic [iffs_pkg::PAIR_W-1:0] out_pair_q;
	logic [iffs_pkg::COL_W-1:0]  out_col_q;
	iffs_pkg::byte_t             out_top_q;
	iffs_pkg::byte_t             out_bot_q;

	logic            accept;
	logic            s1_adv;
	iffs_pkg::byte_t prev;
	iffs_pkg::byte_t new_top;
	iffs_pkg::byte_t new_bot;
	logic            wr_en;
	iffs_pkg::byte_t wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= iffs_pkg::MODE_FLIP;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	assign s1_adv      = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !ram_busy && (!valid_s1 || s1_adv);
	assign accept      = items.valid && items.ready;

	always_comb begin
		ram_req.re    = accept;
		ram_req.raddr = iffs_pkg::store_addr(items.line_pair, items.byte_column);
		ram_req.we    = s1_adv && wr_en;
		ram_req.waddr = addr_s1;
		ram_req.wdata = wr_data;
	end

	iffs_field_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (ram_rdata),
		.busy   (ram_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1 <= items.line_pair;
			col_s1  <= items.byte_column;
			top_s1  <= items.top_byte;
			bot_s1  <= items.bottom_byte;
			addr_s1 <= ram_req.raddr;
		end
	end

	// last write always reflects the RAM, so a hit is safe to take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else if (ram_req.we) begin
			byp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_req.we) begin
			byp_addr_q <= ram_req.waddr;
			byp_data_q <= ram_req.wdata;
		end
	end

	assign prev = (byp_valid_q && byp_addr_q == addr_s1) ? byp_data_q : ram_rdata;

	always_comb begin
		case (mode_q)
			iffs_pkg::MODE_FLIP: begin
				new_top = bot_s1;
				new_bot = top_s1;
				wr_en   = 1'b0;
				wr_data = bot_s1;
			end
			iffs_pkg::MODE_SHIFT: begin
				new_top = prev;
				new_bot = top_s1;
				wr_en   = 1'b1;
				wr_data = bot_s1;
			end
			iffs_pkg::MODE_SHIFT_FLIP: begin
				new_top = top_s1;
				new_bot = prev;
				wr_en   = 1'b1;
				wr_data = bot_s1;
			end
			default: begin
				new_top = prev;
				new_bot = bot_s1;
				wr_en   = 1'b1;
				wr_data = top_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_pair_q <= pair_s1;
			out_col_q  <= col_s1;
			out_top_q  <= new_top;
			out_bot_q  <= new_bot;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.out_line_pair   = out_pair_q;
	assign results.out_byte_column = out_col_q;
	assign results.out_top_byte    = out_top_q;
	assign results.out_bottom_byte = out_bot_q;

endmodule
